// File: design/assert_macros.svh
// Assertion macros shared by the slot table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define OIST_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define OIST_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/oist_pkg.sv
// Types and constants of the owner id slot table.
`default_nettype none

package oist_pkg;

  localparam int unsigned ID_W  = 17;
  localparam int unsigned SIG_W = 8;
  localparam int unsigned TOT_W = 4;
  localparam int unsigned UID_W = 32;

  // valid_total saturates here
  localparam logic [TOT_W-1:0] TOT_MAX = 4'd15;

  // cycles of the reciprocal modulo: quotient, remainder, final correction
  localparam int unsigned MOD_STEPS = 3;

  typedef enum logic [2:0] {
    FN_ADD     = 3'd0,
    FN_REM_ID  = 3'd1,
    FN_REM_SIG = 3'd2,
    FN_LOOKUP  = 3'd3,
    FN_HAS_SIG = 3'd4,
    FN_FIRST   = 3'd5,
    FN_CLEAR   = 3'd6,
    FN_LIST    = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [UID_W-1:0]   user_id;
    logic [SIG_W-1:0]   sig_index;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [ID_W-1:0]    app_id;
    logic [SIG_W-1:0]   entry_sig;
    logic [TOT_W-1:0]   valid_total;
    logic               last;
  } rsp_t;

endpackage

`default_nettype wire

// File: design/oist_stream_if.sv
// Valid/ready stream channel carrying one payload item per transaction.
`default_nettype none

interface oist_stream_if #(
  parameter type item_t = logic
);

  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: design/owner_id_slot_table_core.sv
// Owner id slot table: slot memory, valid bits, modulo unit and scan sequencer.
// Flow: clear goes straight to the finish state; signature ops, first and list scan every slot;
// add, remove id and lookup run the reciprocal modulo (quotient, remainder, correction) before the scan.
// One transaction at a time; the slot scan reads one memory entry per cycle, and
// list stalls the scan while the output register is full.
// Reset clears valid bits, count and handshake state; slot data stays undefined.
`default_nettype none
`include "assert_macros.svh"

module owner_id_slot_table_core
  import oist_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned USER_RANGE = 100000
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  oist_stream_if.sink   req_i,
  oist_stream_if.source rsp_o
);

  localparam int unsigned IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int unsigned RNG_W  = ID_W + 1;
  localparam int unsigned STEP_W = $clog2(MOD_STEPS);
  localparam int unsigned DAT_W  = ID_W + SIG_W;

  localparam logic [RNG_W-1:0]  RANGE_C   = RNG_W'(USER_RANGE);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MOD_STEPS - 1);
  // floor(2^32 / range): the estimated quotient is exact or one short
  localparam logic [UID_W-1:0]  RECIP_C   = UID_W'((64'd1 << UID_W) / 64'(USER_RANGE));

  // Saturate the valid count to the result field
  function automatic logic [TOT_W-1:0] sat_total(input logic [CNT_W-1:0] c);
    logic [CNT_W+TOT_W-1:0] ext;
    ext = {{TOT_W{1'b0}}, c};
    if (ext > (CNT_W + TOT_W)'(TOT_MAX)) begin
      return TOT_MAX;
    end
    return ext[TOT_W-1:0];
  endfunction

  // Control state
  state_e                state_q, state_d;
  func_e                 func_q, func_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  found_q, found_d;
  logic                  free_q, free_d;
  logic                  out_vld_q, out_vld_d;

  // Payload state
  logic [UID_W-1:0]      uid_q, uid_d;
  logic [SIG_W-1:0]      sig_q, sig_d;
  logic [ID_W-1:0]       app_q, app_d;
  logic [RNG_W-1:0]      quo_q, quo_d;
  logic [RNG_W-1:0]      rem_q, rem_d;
  logic [IDX_W-1:0]      fidx_q, fidx_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;
  logic [ID_W-1:0]       keep_id_q, keep_id_d;
  logic [SIG_W-1:0]      keep_sig_q, keep_sig_d;
  rsp_t                  out_q, out_d;

  // Slot memory
  logic [DAT_W-1:0]      mem_q [SLOT_COUNT];
  logic [DAT_W-1:0]      rd_data_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [DAT_W-1:0]      mem_wdata;

  // Datapath helpers
  logic                  out_space;
  logic                  slot_v;
  logic [ID_W-1:0]       rd_id;
  logic [SIG_W-1:0]      rd_sig;
  logic                  id_hit;
  logic                  sig_hit;
  logic [SLOT_COUNT-1:0] slot_onehot;
  logic [SLOT_COUNT-1:0] le_mask;
  logic                  is_last;
  logic [2*UID_W-1:0]    recip_prod;
  logic [RNG_W-1:0]      qr_lo;
  logic [RNG_W-1:0]      rem_red;
  logic                  scan_step;
  logic                  match;
  logic                  emit;
  rsp_t                  out_new;

  assign out_space   = !out_vld_q || rsp_o.ready;
  assign slot_v      = valid_q[idx_q];
  assign rd_id       = rd_data_q[DAT_W-1:SIG_W];
  assign rd_sig      = rd_data_q[SIG_W-1:0];
  assign id_hit      = (rd_id == app_q);
  assign sig_hit     = (rd_sig == sig_q);

  // No valid slot above the current one marks the final list transaction
  assign slot_onehot = SLOT_COUNT'(1) << idx_q;
  assign le_mask     = (slot_onehot << 1) - SLOT_COUNT'(1);
  assign is_last     = ~|(valid_q & ~le_mask);

  // Reciprocal reduction: estimate the quotient, take the low remainder bits,
  // then subtract the range once if the estimate fell one short
  assign recip_prod  = {{UID_W{1'b0}}, uid_q} * {{UID_W{1'b0}}, RECIP_C};
  assign qr_lo       = quo_q * RANGE_C;
  assign rem_red     = rem_q - RANGE_C;

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

  // Next state, datapath updates and handshake
  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    step_d     = step_q;
    idx_d      = idx_q;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    found_d    = found_q;
    free_d     = free_q;
    uid_d      = uid_q;
    sig_d      = sig_q;
    app_d      = app_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    fidx_d     = fidx_q;
    free_idx_d = free_idx_q;
    keep_id_d  = keep_id_q;
    keep_sig_d = keep_sig_q;
    req_i.ready = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = fidx_q;
    mem_wdata  = {app_q, sig_q};
    scan_step  = 1'b0;
    match      = 1'b0;
    emit       = 1'b0;
    out_new    = '0;

    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          func_d     = req_i.payload.func;
          uid_d      = req_i.payload.user_id;
          sig_d      = req_i.payload.sig_index;
          app_d      = '0;
          step_d     = '0;
          idx_d      = '0;
          found_d    = 1'b0;
          free_d     = 1'b0;
          fidx_d     = '0;
          free_idx_d = '0;
          keep_id_d  = '0;
          keep_sig_d = '0;
          case (req_i.payload.func)
            FN_ADD, FN_REM_ID, FN_LOOKUP: state_d = ST_MOD;
            FN_CLEAR:                     state_d = ST_FIN;
            default:                      state_d = ST_SCAN;
          endcase
        end
      end

      ST_MOD: begin
        // advance the three reduction stages; the last one settles on the final step
        quo_d  = recip_prod[UID_W +: RNG_W];
        rem_d  = uid_q[RNG_W-1:0] - qr_lo;
        app_d  = (rem_q >= RANGE_C) ? rem_red[ID_W-1:0] : rem_q[ID_W-1:0];
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_LAST) begin
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        scan_step = 1'b1;
        case (func_q)
          FN_ADD: begin
            if (slot_v && id_hit && !found_q) begin
              found_d = 1'b1;
              fidx_d  = idx_q;
            end
            if (!slot_v && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = idx_q;
            end
          end
          FN_REM_ID, FN_REM_SIG: begin
            match = slot_v && ((func_q == FN_REM_ID) ? id_hit : sig_hit);
            if (match) begin
              valid_d[idx_q] = 1'b0;
              cnt_d          = cnt_q - CNT_W'(1);
              if (!found_q) begin
                found_d    = 1'b1;
                keep_id_d  = rd_id;
                keep_sig_d = rd_sig;
              end
            end
          end
          FN_LOOKUP, FN_HAS_SIG, FN_FIRST: begin
            match = slot_v && ((func_q == FN_LOOKUP)  ? id_hit  :
                               (func_q == FN_HAS_SIG) ? sig_hit : 1'b1);
            if (match && !found_q) begin
              found_d    = 1'b1;
              keep_id_d  = rd_id;
              keep_sig_d = rd_sig;
            end
          end
          FN_LIST: begin
            if (slot_v) begin
              if (out_space) begin
                emit                = 1'b1;
                found_d             = 1'b1;
                out_new.hit         = 1'b1;
                out_new.app_id      = rd_id;
                out_new.entry_sig   = rd_sig;
                out_new.valid_total = sat_total(cnt_q);
                out_new.last        = is_last;
              end else begin
                // hold the slot until the output register frees up
                scan_step = 1'b0;
              end
            end
          end
          default: ;
        endcase
        if (scan_step) begin
          if (idx_q == LAST_IDX) begin
            idx_d   = '0;
            state_d = ST_FIN;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end

      ST_FIN: begin
        if (func_q == FN_LIST && found_q) begin
          // list already delivered its final transaction
          state_d = ST_IDLE;
        end else if (out_space) begin
          emit         = 1'b1;
          state_d      = ST_IDLE;
          out_new.last = 1'b1;
          case (func_q)
            FN_ADD: begin
              if (found_q || free_q) begin
                mem_we            = 1'b1;
                mem_waddr         = found_q ? fidx_q : free_idx_q;
                out_new.hit       = 1'b1;
                out_new.app_id    = app_q;
                out_new.entry_sig = sig_q;
                if (!found_q) begin
                  valid_d[free_idx_q] = 1'b1;
                  cnt_d               = cnt_q + CNT_W'(1);
                end
              end
            end
            FN_CLEAR: begin
              valid_d     = '0;
              cnt_d       = '0;
              out_new.hit = (cnt_q != '0);
            end
            FN_LIST: begin
              out_new.hit = 1'b0;
            end
            default: begin
              out_new.hit       = found_q;
              out_new.app_id    = found_q ? keep_id_q : '0;
              out_new.entry_sig = found_q ? keep_sig_q : '0;
            end
          endcase
          out_new.valid_total = sat_total(cnt_d);
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // Output register: load on emit, drop once taken
    out_vld_d = emit || (out_vld_q && !rsp_o.ready);
    out_d     = emit ? out_new : out_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      func_q    <= FN_ADD;
      step_q    <= '0;
      idx_q     <= '0;
      valid_q   <= '0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      func_q    <= func_d;
      step_q    <= step_d;
      idx_q     <= idx_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      found_q   <= found_d;
      free_q    <= free_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    uid_q      <= uid_d;
    sig_q      <= sig_d;
    app_q      <= app_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    fidx_q     <= fidx_d;
    free_idx_q <= free_idx_d;
    keep_id_q  <= keep_id_d;
    keep_sig_q <= keep_sig_d;
    out_q      <= out_d;
  end

  // Slot memory: prefetch the next scan entry so data lines up with idx_q
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[idx_d];
  end

  // Checks
  `OIST_ASSERT_IMPL(a_cnt_matches_valid, clk_i, rst_ni, state_q == ST_IDLE, cnt_q == CNT_W'($countones(valid_q)), "valid count disagrees with valid bits")
  `OIST_ASSERT_IMPL(a_nonlast_only_in_list, clk_i, rst_ni, out_vld_q && !out_q.last, state_q == ST_SCAN && func_q == FN_LIST, "non-final result outside a list scan")
  `OIST_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, state_q == ST_FIN && func_q == FN_CLEAR && out_space, valid_q == '0 && cnt_q == '0, "clear left valid slots")
  `OIST_ASSERT_IMPL(a_scan_in_range, clk_i, rst_ni, state_q == ST_SCAN, idx_q <= LAST_IDX, "scan index beyond last slot")

endmodule

`default_nettype wire

// File: verif/oist_table_check.sv
// Checker for the owner id slot table: predicts each result and compares it with the block.
module oist_table_check
  import oist_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned USER_RANGE = 100000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  oist_stream_if      req_mon_i,
  oist_stream_if      rsp_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Shadow copy of the slot table
  logic             slot_vld [SLOT_COUNT];
  logic [ID_W-1:0]  slot_id  [SLOT_COUNT];
  logic [SIG_W-1:0] slot_sg  [SLOT_COUNT];

  rsp_t        expected_rsp_q [$];
  int unsigned mismatches;

  // Count valid slots, saturating at the field maximum
  function automatic logic [TOT_W-1:0] occupancy();
    int unsigned n;
    n = 0;
    for (int i = 0; i < SLOT_COUNT; i++) if (slot_vld[i]) n++;
    return (n > TOT_MAX) ? TOT_MAX : TOT_W'(n);
  endfunction

  // Build a result from a slot, or an empty one when there is no hit
  function automatic rsp_t slot_rsp(logic hit, int idx, logic last);
    rsp_t r;
    r = '0;
    r.hit = hit;
    if (hit && idx >= 0) begin
      r.app_id    = slot_id[idx];
      r.entry_sig = slot_sg[idx];
    end
    r.valid_total = occupancy();
    r.last        = last;
    return r;
  endfunction

  // Apply one request to the shadow table and queue the results it causes
  task automatic predict_request(input req_t req);
    logic [ID_W-1:0]  app;
    logic [SIG_W-1:0] kept_sg;
    logic [ID_W-1:0]  kept_id;
    logic             match;
    logic             any;
    int               found;
    int               free_idx;
    int               last_idx;
    rsp_t             r;
    app      = ID_W'(req.user_id % UID_W'(USER_RANGE));
    found    = -1;
    free_idx = -1;
    last_idx = -1;
    kept_id  = '0;
    kept_sg  = '0;
    any      = 1'b0;
    case (req.func)
      FN_ADD: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!slot_vld[i]) begin
            if (free_idx < 0) free_idx = i;
          end else if (slot_id[i] == app) begin
            found = i;
            break;
          end
        end
        if (found < 0 && free_idx >= 0) begin
          found          = free_idx;
          slot_id[found] = app;
          slot_vld[found] = 1'b1;
        end
        if (found >= 0) slot_sg[found] = req.sig_index;
        expected_rsp_q.push_back(slot_rsp(found >= 0, found, 1'b1));
      end
      FN_REM_ID, FN_REM_SIG: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          match = slot_vld[i] && ((req.func == FN_REM_ID) ? (slot_id[i] == app)
                                                          : (slot_sg[i] == req.sig_index));
          if (match) begin
            if (found < 0) begin
              found   = i;
              kept_id = slot_id[i];
              kept_sg = slot_sg[i];
            end
            slot_vld[i] = 1'b0;
          end
        end
        r = slot_rsp(1'b0, -1, 1'b1);
        if (found >= 0) begin
          r.hit       = 1'b1;
          r.app_id    = kept_id;
          r.entry_sig = kept_sg;
        end
        expected_rsp_q.push_back(r);
      end
      FN_LOOKUP, FN_HAS_SIG, FN_FIRST: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!slot_vld[i]) continue;
          if (req.func == FN_LOOKUP && slot_id[i] != app) continue;
          if (req.func == FN_HAS_SIG && slot_sg[i] != req.sig_index) continue;
          found = i;
          break;
        end
        expected_rsp_q.push_back(slot_rsp(found >= 0, found, 1'b1));
      end
      FN_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_vld[i]) any = 1'b1;
          slot_vld[i] = 1'b0;
        end
        expected_rsp_q.push_back(slot_rsp(any, -1, 1'b1));
      end
      default: begin
        // List: one result per valid slot, or a single empty one
        for (int i = 0; i < SLOT_COUNT; i++) if (slot_vld[i]) last_idx = i;
        if (last_idx < 0) begin
          expected_rsp_q.push_back(slot_rsp(1'b0, -1, 1'b1));
        end else begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_vld[i]) expected_rsp_q.push_back(slot_rsp(1'b1, i, i == last_idx));
          end
        end
      end
    endcase
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one result with the oldest expectation
  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (expected_rsp_q.size() == 0) begin
      $display("%0t: extra result, expected none, got hit=%0d id=%0d sig=%0d tot=%0d last=%0d",
               $time, got.hit, got.app_id, got.entry_sig, got.valid_total, got.last);
      mismatches++;
    end else begin
      want = expected_rsp_q.pop_front();
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("app_id", 32'(want.app_id), 32'(got.app_id));
      compare_field("entry_sig", 32'(want.entry_sig), 32'(got.entry_sig));
      compare_field("valid_total", 32'(want.valid_total), 32'(got.valid_total));
      compare_field("last", 32'(want.last), 32'(got.last));
    end
  endtask

  // Watch both channels; check results before queueing new ones
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_vld[i] = 1'b0;
      expected_rsp_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_mon_i.valid && rsp_mon_i.ready) check_result(rsp_mon_i.payload);
      if (req_mon_i.valid && req_mon_i.ready) predict_request(req_mon_i.payload);
      fail_count_o <= mismatches;
      pending_o    <= expected_rsp_q.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for the owner id slot table: clock, reset, stimulus, result stalls and verdict.
module tb_top;
  import oist_pkg::*;

  localparam int unsigned SLOT_COUNT   = 8;
  localparam int unsigned USER_RANGE   = 100000;
  localparam int unsigned RANDOM_ITEMS = 330;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned ID_POOL      = 12;
  localparam int unsigned SIG_POOL     = 6;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned expect_pending;

  // Sender pacing and long hold-off requests
  int unsigned burst_left;
  int unsigned no_gap_left;
  int unsigned hold_req;
  int unsigned hold_done;
  int unsigned idle_cycles;

  logic [UID_W-1:0] id_pool  [ID_POOL];
  logic [SIG_W-1:0] sig_pool [SIG_POOL];

  oist_stream_if #(.item_t(req_t)) req_if ();
  oist_stream_if #(.item_t(rsp_t)) rsp_if ();

  owner_id_slot_table_core #(
    .SLOT_COUNT(SLOT_COUNT),
    .USER_RANGE(USER_RANGE)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  oist_table_check #(
    .SLOT_COUNT(SLOT_COUNT),
    .USER_RANGE(USER_RANGE)
  ) u_table_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon_i   (req_if),
    .rsp_mon_i   (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (expect_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one transaction, hold it until accepted, then pace the next one
  task automatic send_req(input func_e f, input logic [UID_W-1:0] uid,
                          input logic [SIG_W-1:0] sig);
    req_t        r;
    int unsigned gap;
    r.func      = f;
    r.user_id   = uid;
    r.sig_index = sig;
    req_if.payload <= r;
    req_if.valid   <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (no_gap_left > 0) begin
      no_gap_left--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Raw user id: mostly an alias of a pooled app id, sometimes fully random
  function automatic logic [UID_W-1:0] pick_user_id();
    longint unsigned app;
    longint unsigned span;
    if ($urandom_range(0, 9) < 3) return $urandom;
    app  = id_pool[$urandom_range(0, ID_POOL - 1)];
    span = (64'hFFFF_FFFF - app) / USER_RANGE;
    return UID_W'(app + USER_RANGE * longint'($urandom_range(0, int'(span))));
  endfunction

  function automatic logic [SIG_W-1:0] pick_sig();
    if ($urandom_range(0, 4) == 0) return SIG_W'($urandom_range(0, 255));
    return sig_pool[$urandom_range(0, SIG_POOL - 1)];
  endfunction

  function automatic func_e pick_func();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 30) return FN_ADD;
    if (w < 40) return FN_REM_ID;
    if (w < 48) return FN_REM_SIG;
    if (w < 63) return FN_LOOKUP;
    if (w < 73) return FN_HAS_SIG;
    if (w < 81) return FN_FIRST;
    if (w < 85) return FN_CLEAR;
    return FN_LIST;
  endfunction

  // Stimulus and verdict
  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    burst_left     = 0;
    no_gap_left    = 0;
    hold_req       = 0;
    id_pool[0] = 32'd0;
    id_pool[1] = 32'd99999;
    id_pool[2] = 32'd67295;
    for (int i = 3; i < ID_POOL; i++) id_pool[i] = $urandom_range(0, USER_RANGE - 1);
    sig_pool[0] = 8'h00;
    sig_pool[1] = 8'hFF;
    for (int i = 2; i < SIG_POOL; i++) sig_pool[i] = SIG_W'($urandom_range(0, 255));
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: every miss path
    send_req(FN_LIST,    32'd0, 8'd0);
    send_req(FN_FIRST,   32'd0, 8'd0);
    send_req(FN_CLEAR,   32'd0, 8'd0);
    send_req(FN_LOOKUP,  32'd0, 8'd0);
    send_req(FN_REM_ID,  32'd5, 8'd0);
    send_req(FN_REM_SIG, 32'd0, 8'd3);
    send_req(FN_HAS_SIG, 32'd0, 8'd3);
    // Fill with extreme ids; an alias of id 0 refreshes its signature
    send_req(FN_ADD, 32'd0,         8'h00);
    send_req(FN_ADD, 32'hFFFF_FFFF, 8'hFF);
    send_req(FN_ADD, 32'd99999,     8'd3);
    send_req(FN_ADD, 32'd100000,    8'd3);
    send_req(FN_ADD, 32'd212345,    8'd3);
    send_req(FN_ADD, 32'd1,         8'hA5);
    send_req(FN_ADD, 32'd2,         8'h5A);
    send_req(FN_ADD, 32'd3,         8'h80);
    send_req(FN_ADD, 32'd4,         8'h7F);
    // Full table: a new id fails, a known id still refreshes
    send_req(FN_ADD,  32'd7,         8'h11);
    send_req(FN_ADD,  32'hFFFF_FFFF, 8'h01);
    send_req(FN_LIST, 32'd0,         8'd0);
    send_req(FN_LOOKUP,  32'd67295, 8'd0);
    send_req(FN_HAS_SIG, 32'd0,     8'd3);
    // Remove several slots sharing one signature
    send_req(FN_REM_SIG, 32'd0, 8'd3);
    send_req(FN_REM_ID,  32'd1, 8'd0);
    send_req(FN_FIRST,   32'd0, 8'd0);
    send_req(FN_ADD,     32'd7, 8'h11);
    send_req(FN_CLEAR,   32'd0, 8'd0);
    send_req(FN_LIST,    32'd0, 8'd0);

    // Random traffic; part way through, hold the result side while offering back to back
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        hold_req    <= hold_req + 1;
        no_gap_left = 30;
      end
      send_req(pick_func(), pick_user_id(), pick_sig());
    end
    req_if.valid <= 1'b0;

    // Drain outstanding results, then allow for trailing activity
    do @(posedge clk_i); while (expect_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expect_pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Result side: stall on a changing pattern, plus one long hold-off on request
  initial begin
    logic [31:0] stall_pat;
    int unsigned phase_left;
    int unsigned pat_pos;
    rsp_if.ready = 1'b0;
    hold_done    = 0;
    phase_left   = 0;
    pat_pos      = 0;
    stall_pat    = '1;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done++;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(16, 64);
          case ($urandom_range(0, 3))
            0:       stall_pat = '1;
            1:       stall_pat = $urandom;
            2:       stall_pat = $urandom & $urandom;
            default: stall_pat = $urandom | $urandom;
          endcase
        end
        phase_left--;
        rsp_if.ready <= stall_pat[pat_pos];
        pat_pos = (pat_pos + 1) % 32;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/oist_pkg.sv
design/oist_stream_if.sv
design/owner_id_slot_table_core.sv
verif/oist_table_check.sv
verif/tb_top.sv
